// ===== design/rth_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
package rth_pkg;

  localparam int unsigned COMP_W    = 8;   // one color component
  localparam int unsigned HUE_W     = 12;  // tenths of a degree
  localparam int unsigned PCT_W     = 10;  // tenths of a percent
  localparam int unsigned SUM_W     = COMP_W + 1;
  localparam int unsigned HNUM_W    = 21;  // 2N + d, N <= 3600 * 255
  localparam int unsigned SNUM_W    = 19;  // 2000 d + D
  localparam int unsigned DEN_W     = COMP_W + 1;
  localparam int unsigned QUO_W     = HUE_W;
  localparam int unsigned N_W       = 20;

  localparam logic [HUE_W-1:0] HUE_FULL  = 12'd3600;
  localparam logic [PCT_W-1:0] PCT_FULL  = 10'd1000;
  localparam logic [N_W-1:0]   SECT_STEP = 20'd600;   // 60 degrees in tenths
  localparam logic [N_W-1:0]   OFS_GREEN = 20'd1200;
  localparam logic [N_W-1:0]   OFS_BLUE  = 20'd2400;
  localparam logic [N_W-1:0]   OFS_WRAP  = 20'd3600;
  localparam logic [SNUM_W-1:0] SAT_SCALE = 19'd2000;
  localparam logic [SUM_W-1:0] SUM_FULL  = 9'd510;
  localparam logic [SUM_W-1:0] SUM_HALF  = 9'd255;

  // Lightness = floor((200 sum + 51) / 102), done as a reciprocal multiply.
  localparam int unsigned LNUM_W    = 17;
  localparam int unsigned LREC_W    = 18;
  localparam int unsigned LSHIFT    = 24;
  localparam logic [LNUM_W-1:0] L_SCALE = 17'd200;
  localparam logic [LNUM_W-1:0] L_BIAS  = 17'd51;
  localparam logic [LREC_W-1:0] L_RECIP = 18'd164483;  // ceil(2^24 / 102)

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] lightness;
  } pix_out_t;

  // Operands handed from the front end to the divider lanes.
  typedef struct packed {
    logic [HNUM_W-1:0] hue_num;
    logic [DEN_W-1:0]  hue_den;
    logic [SNUM_W-1:0] sat_num;
    logic [DEN_W-1:0]  sat_den;
    logic [PCT_W-1:0]  light;
    logic              grey;
    logic              sat_zero;
  } front_out_t;

endpackage

// ===== design/rth_front.sv =====
// Front end: max/min/sector search, then numerators, denominators and lightness.
module rth_front
  import rth_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  pix_in_t    in_pix,
  output logic       out_valid,
  output front_out_t out_ops
);

  // Stage 1: extremes, sector and the signed difference inside the sector.
  logic [COMP_W-1:0] mx, mn, da, db;
  sector_t           sec;

  logic              v1_r;
  logic [COMP_W-1:0] d1_r, f1_r;
  logic [SUM_W-1:0]  sum1_r;
  sector_t           sec1_r;
  logic              neg1_r;

  always_comb begin
    mx = in_pix.red;
    if (in_pix.green > mx) mx = in_pix.green;
    if (in_pix.blue > mx) mx = in_pix.blue;
    mn = in_pix.red;
    if (in_pix.green < mn) mn = in_pix.green;
    if (in_pix.blue < mn) mn = in_pix.blue;

    // Ties go to red first, then green.
    if (mx == in_pix.red) begin
      sec = SEC_RED;
      da  = in_pix.green;
      db  = in_pix.blue;
    end else if (mx == in_pix.green) begin
      sec = SEC_GREEN;
      da  = in_pix.blue;
      db  = in_pix.red;
    end else begin
      sec = SEC_BLUE;
      da  = in_pix.red;
      db  = in_pix.green;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    d1_r   <= mx - mn;
    sum1_r <= SUM_W'(mx) + SUM_W'(mn);
    sec1_r <= sec;
    neg1_r <= da < db;
    f1_r   <= (da >= db) ? (da - db) : (db - da);
  end

  // Stage 2: operands for both dividers and the lightness product.
  logic [N_W-1:0]           base, step, n_val;
  logic [COMP_W-1:0]        dd;
  logic [LNUM_W-1:0]        lnum;
  logic [LNUM_W+LREC_W-1:0] lprod;
  front_out_t               ops_nxt;

  logic       v2_r;
  front_out_t ops2_r;

  always_comb begin
    step = N_W'(f1_r) * SECT_STEP;
    unique case (sec1_r)
      SEC_RED:   base = neg1_r ? N_W'(d1_r) * OFS_WRAP : '0;
      SEC_GREEN: base = N_W'(d1_r) * OFS_GREEN;
      SEC_BLUE:  base = N_W'(d1_r) * OFS_BLUE;
      default:   base = '0;
    endcase
    n_val = neg1_r ? (base - step) : (base + step);

    dd = (sum1_r <= SUM_HALF) ? sum1_r[COMP_W-1:0] : COMP_W'(SUM_FULL - sum1_r);

    lnum  = LNUM_W'(sum1_r) * L_SCALE + L_BIAS;
    lprod = (LNUM_W + LREC_W)'(lnum) * (LNUM_W + LREC_W)'(L_RECIP);

    ops_nxt.hue_num  = {n_val, 1'b0} + HNUM_W'(d1_r);
    ops_nxt.hue_den  = {d1_r, 1'b0};
    ops_nxt.sat_num  = SNUM_W'(d1_r) * SAT_SCALE + SNUM_W'(dd);
    ops_nxt.sat_den  = {dd, 1'b0};
    ops_nxt.light    = lprod[LSHIFT +: PCT_W];
    ops_nxt.grey     = d1_r == '0;
    ops_nxt.sat_zero = dd == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    ops2_r <= ops_nxt;
  end

  assign out_valid = v2_r;
  assign out_ops   = ops2_r;

endmodule

// ===== design/rth_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
module rth_div
  import rth_pkg::*;
#(
  parameter int unsigned NUM_W  = 21,
  parameter int unsigned DW     = 9,
  parameter int unsigned Q_W    = 12,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DW-1:0]     in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quo,
  output logic [SIDE_W-1:0] out_side
);

  // The quotient must fit Q_W bits, so the numerator's top bits start below den.
  logic              v_r    [Q_W];
  logic [DW-1:0]     rem_r  [Q_W];
  logic [DW-1:0]     den_r  [Q_W];
  logic [Q_W-1:0]    lo_r   [Q_W];
  logic [Q_W-1:0]    q_r    [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic              v_in;
    logic [DW-1:0]     rem_in, den_in;
    logic [Q_W-1:0]    lo_in, q_in;
    logic [SIDE_W-1:0] side_in;
    logic [DW:0]       trial;
    logic              take;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = DW'(in_num[NUM_W-1:Q_W]);
      assign den_in  = in_den;
      assign lo_in   = in_num[Q_W-1:0];
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign lo_in   = lo_r[i-1];
      assign q_in    = q_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign trial = {rem_in, lo_in[Q_W-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
      rem_r[i]  <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      den_r[i]  <= den_in;
      lo_r[i]   <= lo_in << 1;
      q_r[i]    <= {q_in[Q_W-2:0], take};
      side_r[i] <= side_in;
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign out_quo   = q_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];

endmodule

// ===== design/rgb_to_hsl_convert.sv =====
// Top level of the RGB to HSL converter: front end, two divider lanes, output register.
//
// Converts one 8-bit RGB pixel per beat into hue (tenths of a degree, 0..3599),
// saturation and lightness (tenths of a percent, 0..1000), all rounded to
// nearest with halves rounded up; grey pixels give hue 0, black and white give
// saturation 0, and ties for the largest component favor red, then green. A
// pixel is taken on any clock edge with start high; busy is never raised, so a
// new pixel may enter every cycle. Each result appears for exactly one cycle
// with out_valid high once its pixel has passed two front-end stages
// (extremes and sector, then the operands and the lightness reciprocal
// multiply), twelve stages of the bit-per-stage divider lanes that form hue
// and saturation, and one output register. Results come out in input order,
// and the receiver cannot hold them off.
module rgb_to_hsl_convert
  import rth_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pix_in_t  in_pix,
  output logic     out_valid,
  output pix_out_t out_pix
);

  localparam int unsigned HSIDE_W = PCT_W + 1;

  logic       accept;
  logic       fr_valid;
  front_out_t fr_ops;

  logic               hd_valid, sd_valid;
  logic [QUO_W-1:0]   hd_quo, sd_quo;
  logic [HSIDE_W-1:0] hd_side;
  logic               sd_side;

  logic     out_valid_r;
  pix_out_t out_pix_r, out_pix_nxt;

  // The pipeline never stalls, so the input side is always open.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rth_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_pix    (in_pix),
    .out_valid (fr_valid),
    .out_ops   (fr_ops)
  );

  // Hue lane carries lightness and the grey flag alongside the quotient.
  rth_div #(
    .NUM_W  (HNUM_W),
    .DW     (DEN_W),
    .Q_W    (QUO_W),
    .SIDE_W (HSIDE_W)
  ) u_hue_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_num    (fr_ops.hue_num),
    .in_den    (fr_ops.hue_den),
    .in_side   ({fr_ops.light, fr_ops.grey}),
    .out_valid (hd_valid),
    .out_quo   (hd_quo),
    .out_side  (hd_side)
  );

  // Saturation lane; its divisor is zero for black and white, masked below.
  rth_div #(
    .NUM_W  (SNUM_W),
    .DW     (DEN_W),
    .Q_W    (QUO_W),
    .SIDE_W (1)
  ) u_sat_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_num    (fr_ops.sat_num),
    .in_den    (fr_ops.sat_den),
    .in_side   (fr_ops.sat_zero),
    .out_valid (sd_valid),
    .out_quo   (sd_quo),
    .out_side  (sd_side)
  );

  // Fold a rounded-up 360.0 back to 0, and drop hue/saturation for the special cases.
  always_comb begin
    if (hd_side[0]) begin
      out_pix_nxt.hue = '0;
    end else if (hd_quo >= HUE_FULL) begin
      out_pix_nxt.hue = hd_quo - HUE_FULL;
    end else begin
      out_pix_nxt.hue = hd_quo;
    end
    out_pix_nxt.saturation = sd_side ? '0 : sd_quo[PCT_W-1:0];
    out_pix_nxt.lightness  = hd_side[HSIDE_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= hd_valid;
    end
    out_pix_r <= out_pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

  // Both divider lanes must stay in lockstep.
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    hd_valid == sd_valid)
    else $error("hue and saturation lanes out of step");

  // Every result beat traces back to a pixel that was taken earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 15))
    else $error("result beat without a matching input beat");

  // Delivered values stay in range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pix.hue < HUE_FULL) && (out_pix.saturation <= PCT_FULL)
                  && (out_pix.lightness <= PCT_FULL))
    else $error("result out of range");

  // A saturation quotient only exceeds full scale (1000) if the lane slipped.
  a_sat_quo: assert property (@(posedge clk) disable iff (!rst_n)
    (sd_valid && !sd_side) |-> (sd_quo <= QUO_W'(PCT_FULL)))
    else $error("saturation quotient above full scale");

endmodule
